/* hw/rtl/ipe_pkg.sv */
package ipe_pkg;

  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // Per-item control handed from the position stage to the window stage.
  // rows[k] is set when row (in_row - 3 + k) lies inside the frame.
  typedef struct packed {
    logic       x;
    logic [3:0] rows;
    logic       left_start;
    logic       left_mid;
    logic       have_start;
    logic       have_mid;
    logic       last;
  } ipe_ctl_t;

  // win: bits 2:0 left column, 5:3 middle, 8:6 right; bit 0 of a column is the top row.
  function automatic logic pixel_decide(logic [8:0] win, logic [2:0] rows, logic left_ok);
    logic [2:0] left;
    logic [2:0] mid;
    logic [2:0] right;
    logic       centre;
    logic       isolated;
    left     = left_ok ? (win[2:0] & rows) : 3'b000;
    mid      = win[5:3] & rows;
    right    = win[8:6] & rows;
    centre   = mid[1];
    isolated = centre && ((left | right | (mid & 3'b101)) == 3'b000);
    return isolated ? 1'b1 : centre;
  endfunction

endpackage

/* hw/rtl/ipe_ram.sv */
module ipe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the address being written returns the old entry.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* hw/rtl/ipe_front.sv */
module ipe_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT + 3)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [ipe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ipe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              pix_valid,
  input  logic                              action,
  input  logic                              pixel_black,
  input  logic                              adv,
  output logic [CW-1:0]                     rd_addr,
  output logic                              s2_valid,
  output logic [CW-1:0]                     s2_col,
  output ipe_pkg::ipe_ctl_t                 s2_ctl
);

  import ipe_pkg::*;

  localparam int EWW = CW + 1;

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [CW-1:0]           in_column;
  logic [CW-1:0]           col_next;
  logic [RW-1:0]           in_row;
  logic [RW-1:0]           row_next;
  logic [EWW-1:0]          eff_width;
  logic [RW-1:0]           eff_height;
  logic [CW-1:0]           ci;
  logic                    beyond;
  logic                    take;
  logic                    col_end;
  ipe_ctl_t                ctl;

  always_comb begin
    if (image_width == '0) begin
      eff_width = EWW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_width = EWW'(MAX_WIDTH);
    end else begin
      eff_width = EWW'(image_width);
    end
    if (image_height == '0) begin
      eff_height = RW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_height = RW'(MAX_HEIGHT);
    end else begin
      eff_height = RW'(image_height);
    end
  end

  always_comb begin
    // wrap a column left over from a wider frame
    ci      = (int'(in_column) >= int'(eff_width)) ? '0 : in_column;
    beyond  = int'(in_row) >= int'(eff_height);
    // drop a drain item while pixels of the frame are still expected
    take    = pix_valid && adv && !(action && !beyond);
    col_end = (int'(ci) + 1) >= int'(eff_width);

    ctl.x = !beyond && pixel_black;
    for (int k = 0; k < 4; k++) begin
      ctl.rows[k] = ((int'(in_row) + k) >= 3) && ((int'(in_row) + k) < (int'(eff_height) + 3));
    end
    ctl.left_start = int'(eff_width) >= 2;
    ctl.left_mid   = int'(ci) >= 2;
    ctl.have_start = (ci == '0) && (int'(in_row) >= 2);
    ctl.have_mid   = (ci != '0) && (in_row != '0);
    ctl.last       = ctl.have_start && (int'(in_row) >= (int'(eff_height) + 1));

    col_next = in_column;
    row_next = in_row;
    if (take) begin
      if (ctl.last) begin
        col_next = '0;
        row_next = '0;
      end else if (col_end) begin
        col_next = '0;
        row_next = in_row + RW'(1);
      end else begin
        col_next = ci + CW'(1);
      end
    end
  end

  assign rd_addr = ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      s2_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      in_column <= col_next;
      in_row    <= row_next;
      if (adv) begin
        s2_valid <= take;
      end
    end
    if (adv) begin
      s2_col <= ci;
      s2_ctl <= ctl;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    take && ctl.last |=> (in_column == '0) && (in_row == '0))
    else $error("position not cleared after the final pixel of a frame");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s2_valid) && $stable(s2_col) && $stable(in_row))
    else $error("front stage moved while the pipeline was held");

endmodule

/* hw/rtl/ipe_window.sv */
module ipe_window #(
  parameter int CW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              s2_valid,
  input  logic [CW-1:0]     s2_col,
  input  ipe_pkg::ipe_ctl_t s2_ctl,
  input  logic [CW-1:0]     rd_addr,
  input  logic [1:0]        rd_data,
  output logic              wr_en,
  output logic [CW-1:0]     wr_addr,
  output logic [1:0]        wr_data,
  output logic              res_valid,
  output logic              out_black,
  output logic              frame_last
);

  import ipe_pkg::*;

  logic [8:0] window;
  logic [8:0] win_shift;
  logic [8:0] window_next;
  logic       byp;
  logic [1:0] byp_data;
  logic [1:0] entry;
  logic       start_res;
  logic       mid_res;

  always_comb begin
    // entry bit 0: two rows up, bit 1: one row up
    entry       = byp ? byp_data : rd_data;
    win_shift   = {s2_ctl.x, entry[1], entry[0], window[8:3]};
    // row start finishes the previous row's last pixel; nothing to its right
    start_res   = pixel_decide({3'b000, window[8:3]}, s2_ctl.rows[2:0], s2_ctl.left_start);
    mid_res     = pixel_decide(win_shift, s2_ctl.rows[3:1], s2_ctl.left_mid);
    window_next = s2_ctl.last ? '0 : win_shift;
  end

  assign wr_en   = adv && s2_valid;
  assign wr_addr = s2_col;
  assign wr_data = {s2_ctl.x, entry[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      res_valid <= 1'b0;
      byp       <= 1'b0;
    end else if (adv) begin
      if (s2_valid) begin
        window <= window_next;
      end
      res_valid <= s2_valid && (s2_ctl.have_start || s2_ctl.have_mid);
      // forward the entry being written when the next read hits the same column
      byp       <= wr_en && (rd_addr == s2_col);
    end
    if (adv) begin
      byp_data   <= wr_data;
      out_black  <= s2_ctl.have_mid ? mid_res : start_res;
      frame_last <= s2_ctl.last;
    end
  end

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    adv && s2_valid && s2_ctl.last |=> window == '0)
    else $error("window not cleared at end of frame");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    adv && s2_valid && s2_ctl.last |=> res_valid && frame_last)
    else $error("final pixel of a frame not delivered");

endmodule

/* hw/rtl/isolated_pixel_eraser.sv */
// Streaming 3x3 isolated-pixel cleaner for binary images in raster order.
// Pixel channel: pix_valid / pix_stall with action (0 pixel, 1 drain) and
// pixel_black. Result channel: res_valid / res_stall with out_black and
// frame_last. Each pixel comes back one row and one column after it arrives;
// after the last pixel of a frame, send drain items until frame_last is seen.
// Drain items sent while the frame still expects pixels produce nothing.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// image_width (0) or image_height (1); write only while the block is empty.
// Throughput is one item per cycle, limited by the single line-store memory
// (one registered read and one write per cycle). An accepted item is registered
// in the front stage, and its result then in the window stage's output register.
// When res_stall holds a waiting result, pix_stall rises and the whole
// pipeline holds; otherwise a new item is taken every cycle.
// Reset (rst, synchronous) restores 640 x 480, clears positions, window and
// valid flags. The line store is not cleared; rows outside the frame are masked.
module isolated_pixel_eraser #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  logic                            action,
  input  logic                            pixel_black,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            out_black,
  output logic                            frame_last
);

  import ipe_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          adv;
  logic [CW-1:0] rd_addr;
  logic [1:0]    rd_data;
  logic          s2_valid;
  logic [CW-1:0] s2_col;
  ipe_ctl_t      s2_ctl;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [1:0]    wr_data;

  // hold everything while a finished result waits on a stalled receiver
  assign adv       = !(res_valid && res_stall);
  assign pix_stall = !adv;
  assign cfg_ready = 1'b1;

  ipe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_valid   (pix_valid),
    .action      (action),
    .pixel_black (pixel_black),
    .adv         (adv),
    .rd_addr     (rd_addr),
    .s2_valid    (s2_valid),
    .s2_col      (s2_col),
    .s2_ctl      (s2_ctl)
  );

  // bit 0: older row, bit 1: newer row
  ipe_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ipe_window #(
    .CW (CW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .s2_valid   (s2_valid),
    .s2_col     (s2_col),
    .s2_ctl     (s2_ctl),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .res_valid  (res_valid),
    .out_black  (out_black),
    .frame_last (frame_last)
  );

endmodule

/* sim/isolated_pixel_eraser_test.sv */
`timescale 1ns / 100ps

module isolated_pixel_eraser_test;
  import ipe_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int ROWS_MAX = 4096;
  localparam int LIMIT    = 2_000_000;
  localparam int SETTLE   = 8;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic out_black;
    logic frame_last;
  } pixel_result_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   pix_valid   = 1'b0;
  logic                   pix_stall;
  logic                   action      = ACT_PIXEL;
  logic                   pixel_black = 1'b0;
  logic                   res_valid;
  logic                   res_stall   = 1'b0;
  logic                   out_black;
  logic                   frame_last;

  // predictor state
  logic [IMG_WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
  logic [IMG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  logic                    older_line [LINE_MAX];
  logic                    newer_line [LINE_MAX];
  logic [8:0]              window_bits = '0;
  int unsigned             col_pos     = 0;
  int unsigned             row_pos     = 0;

  pixel_result_t expected_pixels[$];
  pixel_result_t want;

  int unsigned cycle_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done     = 0;
  int unsigned mismatch_count  = 0;

  bit          sender_steady = 1'b0;
  int unsigned burst_left    = 0;

  int          hold_request = 0;
  int          hold_left    = 0;
  int          stall_phase  = 0;
  logic [15:0] stall_mask   = '0;

  isolated_pixel_eraser i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .action     (action),
    .pixel_black(pixel_black),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_black  (out_black),
    .frame_last (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  // receiver: rotating stall pattern, redrawn each time stall_phase wraps, plus long hold-offs
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_mask = '0;
        1: stall_mask = 16'($urandom & $urandom);
        2: stall_mask = 16'($urandom);
        default: stall_mask = 16'($urandom | $urandom);
      endcase
      // keep one gap in the pattern so no stall lasts forever
      stall_mask[$urandom_range(0, 15)] = 1'b0;
    end
    stall_phase = (stall_phase + 1) % 64;
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= stall_mask[stall_phase % 16];
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: out_black %0b frame_last %0b", out_black, frame_last);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (want.out_black !== out_black || want.frame_last !== frame_last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: out_black exp %0b got %b, frame_last exp %0b got %b",
                     results_checked, want.out_black, out_black, want.frame_last,
                     frame_last);
          end
        end
        results_checked++;
        if (want.frame_last) begin
          frames_done++;
        end
      end
    end
  end

  function automatic int unsigned frame_cols();
    int unsigned c;
    c = width_reg;
    if (c < 1) c = 1;
    if (c > LINE_MAX) c = LINE_MAX;
    return c;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned r;
    r = height_reg;
    if (r < 1) r = 1;
    if (r > ROWS_MAX) r = ROWS_MAX;
    return r;
  endfunction

  // win: bits 2:0 left column, 5:3 middle, 8:6 right; bit 0 is the top row
  function automatic logic cleaned_pixel(logic [8:0] win, int centre_row, int rows,
                                         bit left_ok);
    logic [2:0] in_frame;
    logic [2:0] lft;
    logic [2:0] mid;
    logic [2:0] rgt;
    for (int k = 0; k < 3; k++) begin
      in_frame[k] = (centre_row - 1 + k >= 0) && (centre_row - 1 + k < rows);
    end
    lft = left_ok ? (win[2:0] & in_frame) : 3'b000;
    mid = win[5:3] & in_frame;
    rgt = win[8:6] & in_frame;
    // an isolated centre is handed back black, as is any other black centre
    if (mid[1] && (lft | rgt | (mid & 3'b101)) == 3'b000) return 1'b1;
    return mid[1];
  endfunction

  task automatic clean_pixel_step(input logic act, input logic px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   ci;
    logic          x;
    logic          a;
    logic          b;
    bit            have;
    pixel_result_t res;
    w = frame_cols();
    h = frame_rows();
    // drop drains while the frame still expects pixels
    if (act == ACT_DRAIN && row_pos < h) return;
    x = (row_pos >= h) ? 1'b0 : px;
    ci = (col_pos >= w) ? 0 : col_pos;
    have = 1'b0;
    res = '0;
    if (ci == 0 && row_pos >= 2) begin
      res.out_black = cleaned_pixel({3'b000, window_bits[8:3]}, int'(row_pos) - 2, h, w >= 2);
      res.frame_last = (row_pos >= h + 1);
      have = 1'b1;
    end
    a = older_line[ci];
    b = newer_line[ci];
    older_line[ci] = b;
    newer_line[ci] = x;
    window_bits = {x, b, a, window_bits[8:3]};
    if (ci >= 1 && row_pos >= 1) begin
      res.out_black = cleaned_pixel(window_bits, int'(row_pos) - 1, h, ci >= 2);
      have = 1'b1;
    end
    if (ci + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos = ci + 1;
    end
    if (!have) return;
    expected_pixels.push_back(res);
    if (res.frame_last) begin
      window_bits = '0;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic send_item(input logic act, input logic px);
    pix_valid <= 1'b1;
    action <= act;
    pixel_black <= px;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    clean_pixel_step(act, px);
    items_sent++;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        pix_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  // density below zero takes the pixels from pattern, in raster order
  task automatic send_frame(input int density, input logic [63:0] pattern,
                            input int noise_pct, input int tail_pixel_pct);
    int unsigned w;
    int unsigned h;
    logic        px;
    w = frame_cols();
    h = frame_rows();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(ACT_DRAIN, 1'($urandom_range(0, 1)));
      end
      if (density < 0) px = pattern[i];
      else px = ($urandom_range(0, 99) < density);
      send_item(ACT_PIXEL, px);
    end
    // push out the last row and column; pixels here act as drains
    for (int i = 0; i <= w; i++) begin
      send_item(($urandom_range(0, 99) < tail_pixel_pct) ? ACT_PIXEL : ACT_DRAIN,
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    pix_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = wdata[IMG_WIDTH_W-1:0];
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= hdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_reg = hdata[IMG_HEIGHT_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_frames();
    settle();
    set_frame_size(13'd3, 13'd3);
    // lone corner pixel plus a diagonal pair, with drain noise mid-frame
    send_frame(-1, 64'h0A1, 25, 50);
    settle();
    set_frame_size(13'd1, 13'd1);
    send_frame(100, '0, 0, 100);
    settle();
    set_frame_size(13'd2, 13'd2);
    send_frame(100, '0, 0, 0);
  endtask

  task automatic test_size_extremes();
    settle();
    // zero width and zero height both saturate to 1
    set_frame_size(13'd0, 13'd0);
    send_frame(100, '0, 0, 100);
    settle();
    // width bits above the register are dropped, leaving zero: one column
    set_frame_size(13'h1800, 13'd24);
    send_frame(50, '0, 5, 50);
    settle();
    set_frame_size(13'd24, 13'd0);
    send_frame(50, '0, 5, 50);
  endtask

  task automatic test_output_hold_off();
    settle();
    set_frame_size(13'd32, 13'd12);
    sender_steady = 1'b1;
    hold_request = 300;
    send_frame(30, '0, 0, 50);
    sender_steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned budget;
    int          density;
    logic [10:0] wraw;
    logic [12:0] hraw;
    budget = 0;
    while (budget < 500) begin
      // keep the size for back-to-back frames now and then
      if (budget == 0 || $urandom_range(0, 2) != 0) begin
        settle();
        wraw = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 64))
                                           : 11'($urandom_range(1, 12));
        hraw = 13'($urandom_range(0, 10));
        set_frame_size({2'($urandom_range(0, 3)), wraw}, hraw);
      end
      sender_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: density = 0;
        1: density = 5;
        2: density = 15;
        3: density = 50;
        4: density = 85;
        default: density = 100;
      endcase
      send_frame(density, '0, $urandom_range(0, 15), $urandom_range(0, 100));
      budget += frame_cols() * frame_rows() + frame_cols() + 1;
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < LINE_MAX; i++) begin
      older_line[i] = 1'b0;
      newer_line[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_size_extremes();
    test_output_hold_off();
    test_random_frames();
    settle();
    if (expected_pixels.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", expected_pixels.size());
    end
    $display("Sent %0d items; checked %0d pixels over %0d frames from 1x1 up to 64 wide,",
             items_sent, results_checked, frames_done);
    $display("with saturated sizes, drain noise, pixels past the end and a long hold-off.");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ipe_pkg.sv
hw/rtl/ipe_ram.sv
hw/rtl/ipe_front.sv
hw/rtl/ipe_window.sv
hw/rtl/isolated_pixel_eraser.sv
sim/isolated_pixel_eraser_test.sv
